>>> hdl/lrof_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrof_pkg
// Shared types and the per-sample outlier decision of the lidar range filter.
// ----------------------------------------------------------------------------
package lrof_pkg;

  localparam int unsigned RangeW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_RANGE_FLOOR   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_CEILING = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NEAR_CUTOFF   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_NEIGHBOUR_GAP = 2'd3;

  localparam logic [RangeW-1:0] RANGE_SAT = 16'hFFFF;

  typedef struct packed {
    logic [RangeW-1:0] range_floor;
    logic [RangeW-1:0] range_ceiling;
    logic [RangeW-1:0] near_cutoff;
    logic [RangeW-1:0] neighbour_gap;
  } lrof_cfg_t;

  typedef struct packed {
    logic [RangeW-1:0] range_mm;
    logic              nan;
    logic              removed;
    logic              scan_end;
  } lrof_res_t;

  // neighbour is a number strictly inside the sensor range
  function automatic logic nb_valid(lrof_cfg_t c, logic present, logic nan,
                                    logic [RangeW-1:0] v);
    return present && !nan && (v > c.range_floor) && (v < c.range_ceiling);
  endfunction

  // neighbour is absent, or a present number lying farther than the allowed gap
  function automatic logic nb_far(lrof_cfg_t c, logic present, logic nan,
                                  logic [RangeW-1:0] v, logic [RangeW-1:0] x);
    logic [RangeW-1:0] d;
    d = (v > x) ? (v - x) : (x - v);
    if (!present) return 1'b1;
    if (nan) return 1'b0;
    return d > c.neighbour_gap;
  endfunction

  // decide one sample from its left (filtered) and right (raw) neighbours
  function automatic lrof_res_t filter_one(lrof_cfg_t c,
                                           logic [RangeW-1:0] x, logic xnan,
                                           logic lp, logic lnan, logic [RangeW-1:0] l,
                                           logic rp, logic rnan, logic [RangeW-1:0] r);
    logic              rem;
    logic              any_valid;
    logic [RangeW-1:0] repl;
    lrof_res_t         res;
    any_valid = nb_valid(c, lp, lnan, l) || nb_valid(c, rp, rnan, r);
    repl = (c.range_ceiling == RANGE_SAT) ? RANGE_SAT : (c.range_ceiling + 16'd1);
    if (xnan) begin
      rem = !any_valid;
    end else if ((x > c.range_ceiling) || (x < c.range_floor)) begin
      rem = 1'b0;
    end else if (x < c.near_cutoff) begin
      rem = 1'b1;
    end else if (!any_valid) begin
      rem = 1'b1;
    end else begin
      rem = nb_far(c, lp, lnan, l, x) && nb_far(c, rp, rnan, r, x);
    end
    res.removed  = rem;
    res.scan_end = 1'b0;
    if (rem) begin
      res.range_mm = repl;
      res.nan      = 1'b0;
    end else begin
      res.range_mm = xnan ? '0 : x;
      res.nan      = xnan;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lrof_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrof_in_if
// Sample channel: one raw range sample per beat.
// ----------------------------------------------------------------------------
interface lrof_in_if;
  logic                           valid;
  logic                           ready;
  logic [lrof_pkg::RangeW-1:0]    range_mm;
  logic                           is_nan;
  logic                           scan_end;

  modport source (output valid, output range_mm, output is_nan, output scan_end,
                  input ready);
  modport sink   (input valid, input range_mm, input is_nan, input scan_end,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/lrof_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrof_out_if
// Result channel: one filtered sample per beat.
// ----------------------------------------------------------------------------
interface lrof_out_if;
  logic                           valid;
  logic                           ready;
  logic [lrof_pkg::RangeW-1:0]    out_range_mm;
  logic                           out_nan;
  logic                           was_removed;
  logic                           out_scan_end;

  modport source (output valid, output out_range_mm, output out_nan,
                  output was_removed, output out_scan_end, input ready);
  modport sink   (input valid, input out_range_mm, input out_nan,
                  input was_removed, input out_scan_end, output ready);
endinterface
`default_nettype wire

>>> hdl/lidar_range_outlier_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_range_outlier_filter_unit
// Removes isolated range samples from a lidar scan stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries raw samples (range_mm, is_nan, scan_end) one per beat;
//   out_ch carries filtered samples. cfg_we/cfg_index/cfg_wdata write the
//   floor, ceiling, near cut-off and neighbour gap registers, while idle.
//   Each sample is decided once its raw right neighbour arrives, so a
//   result belongs to the previous input beat; the beat marked scan_end
//   releases both the previous sample and its own, which ends the scan.
//   An accepted beat is held in the input register, filtered there and
//   written to a four-entry result queue when the queue has room; its
//   results are offered from the queue once written.
//   Throughput is one sample per cycle while the receiver keeps up; the
//   beat closing a scan adds one extra result, drained by the queue.
//   in_ch.ready drops only when the queue holds more than two results,
//   i.e. when the receiver stalls.
//   Reset (rst_n low, synchronous) empties the queue and the input stage,
//   restores the register defaults and starts a fresh scan.
// ----------------------------------------------------------------------------
module lidar_range_outlier_filter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lrof_in_if.sink                            in_ch,
  lrof_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lrof_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lrof_pkg::RangeW-1:0]   cfg_wdata
);

  lrof_pkg::lrof_cfg_t             cfg_r;

  logic                            s1_v_r;
  logic [lrof_pkg::RangeW-1:0]     s1_range_r;
  logic                            s1_nan_r;
  logic                            s1_end_r;

  logic [lrof_pkg::RangeW-1:0]     prev_range_r, prev_range_nxt;
  logic                            prev_nan_r, prev_nan_nxt;
  logic [lrof_pkg::RangeW-1:0]     pend_range_r, pend_range_nxt;
  logic                            pend_nan_r, pend_nan_nxt;
  logic                            pend_valid_r, pend_valid_nxt;
  logic                            pend_first_r, pend_first_nxt;

  logic [lrof_pkg::FifoCntW-1:0]   fifo_count;
  logic                            s1_move;
  logic                            in_take;
  logic                            push0_v, push1_v;
  lrof_pkg::lrof_res_t             res_a, res_b;
  logic [lrof_pkg::RangeW-1:0]     left_range;
  logic                            left_nan;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_floor   <= 16'd0;
      cfg_r.range_ceiling <= 16'd65534;
      cfg_r.near_cutoff   <= 16'd0;
      cfg_r.neighbour_gap <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        lrof_pkg::CFG_RANGE_FLOOR:   cfg_r.range_floor   <= cfg_wdata;
        lrof_pkg::CFG_RANGE_CEILING: cfg_r.range_ceiling <= cfg_wdata;
        lrof_pkg::CFG_NEAR_CUTOFF:   cfg_r.near_cutoff   <= cfg_wdata;
        lrof_pkg::CFG_NEIGHBOUR_GAP: cfg_r.neighbour_gap <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage advances when the queue has room for two results
  assign s1_move     = s1_v_r && (fifo_count <= lrof_pkg::FifoCntW'(2));
  assign in_ch.ready = !s1_v_r || s1_move;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_range_r <= in_ch.range_mm;
      s1_nan_r   <= in_ch.is_nan;
      s1_end_r   <= in_ch.scan_end;
    end
  end

  // pending sample decided with the new raw sample as right neighbour
  always_comb begin
    res_a = lrof_pkg::filter_one(cfg_r, pend_range_r, pend_nan_r,
                                 !pend_first_r, prev_nan_r, prev_range_r,
                                 1'b1, s1_nan_r, s1_range_r);
    res_a.scan_end = 1'b0;
  end

  // left neighbour of the closing sample is the result just made, if any
  assign left_range = pend_valid_r ? res_a.range_mm : prev_range_r;
  assign left_nan   = pend_valid_r ? res_a.nan      : prev_nan_r;

  // closing sample of the scan has no right neighbour
  always_comb begin
    res_b = lrof_pkg::filter_one(cfg_r, s1_range_r, s1_nan_r,
                                 pend_valid_r, left_nan, left_range,
                                 1'b0, 1'b0, '0);
    res_b.scan_end = 1'b1;
  end

  assign push0_v = s1_move && pend_valid_r;
  assign push1_v = s1_move && s1_end_r;

  // scan state update
  always_comb begin
    prev_range_nxt = prev_range_r;
    prev_nan_nxt   = prev_nan_r;
    pend_range_nxt = pend_range_r;
    pend_nan_nxt   = pend_nan_r;
    pend_valid_nxt = pend_valid_r;
    pend_first_nxt = pend_first_r;
    if (s1_move) begin
      if (pend_valid_r) begin
        prev_range_nxt = res_a.range_mm;
        prev_nan_nxt   = res_a.nan;
        pend_first_nxt = 1'b0;
      end
      if (s1_end_r) begin
        prev_range_nxt = res_b.range_mm;
        prev_nan_nxt   = res_b.nan;
        pend_valid_nxt = 1'b0;
        pend_first_nxt = 1'b1;
      end else begin
        pend_range_nxt = s1_range_r;
        pend_nan_nxt   = s1_nan_r;
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_range_r <= '0;
      prev_nan_r   <= 1'b0;
      pend_range_r <= '0;
      pend_nan_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_first_r <= 1'b1;
    end else begin
      prev_range_r <= prev_range_nxt;
      prev_nan_r   <= prev_nan_nxt;
      pend_range_r <= pend_range_nxt;
      pend_nan_r   <= pend_nan_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_first_r <= pend_first_nxt;
    end
  end

  // result queue
  lrof_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push0_v (push0_v),
    .push0_d (res_a),
    .push1_v (push1_v),
    .push1_d (res_b),
    .count   (fifo_count),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> hdl/lrof_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrof_result_fifo
// Four-entry result queue taking up to two results a cycle, one out a beat.
// ----------------------------------------------------------------------------
module lrof_result_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push0_v,
  input  wire lrof_pkg::lrof_res_t           push0_d,
  input  wire logic                          push1_v,
  input  wire lrof_pkg::lrof_res_t           push1_d,
  output      logic [lrof_pkg::FifoCntW-1:0] count,
  lrof_out_if.source                         out_ch
);

  lrof_pkg::lrof_res_t              mem_r [lrof_pkg::FifoDepth];
  logic [lrof_pkg::FifoPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lrof_pkg::FifoPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lrof_pkg::FifoCntW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]                       n_push;
  logic                             pop;
  lrof_pkg::lrof_res_t              slot0_d;

  // first write slot takes the earlier result
  assign slot0_d = push0_v ? push0_d : push1_d;
  assign n_push  = {1'b0, push0_v} + {1'b0, push1_v};
  assign pop     = (cnt_r != '0) && out_ch.ready;

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lrof_pkg::FifoPtrW'(n_push);
    rd_ptr_nxt = rd_ptr_r + lrof_pkg::FifoPtrW'(pop);
    cnt_nxt    = cnt_r + lrof_pkg::FifoCntW'(n_push) - lrof_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= slot0_d;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + lrof_pkg::FifoPtrW'(1)] <= push1_d;
    end
  end

  assign count               = cnt_r;
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_range_mm = mem_r[rd_ptr_r].range_mm;
  assign out_ch.out_nan      = mem_r[rd_ptr_r].nan;
  assign out_ch.was_removed  = mem_r[rd_ptr_r].removed;
  assign out_ch.out_scan_end = mem_r[rd_ptr_r].scan_end;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar range outlier filter. A short table of
// directed scans comes first, then random scans under eight register settings
// and four flow-control mixes. Every result beat is compared field by field
// with an in-bench model of the filter that tracks the scan state.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int NROWS         = 32;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 175;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [lrof_pkg::CfgIdxW-1:0] reg_idx;
    logic [lrof_pkg::RangeW-1:0]  value;
    logic                         nan;
    logic                         last;
    logic                         typed;
    lrof_pkg::lrof_res_t          want;
  } stim_row_t;

  localparam lrof_pkg::lrof_res_t NO_RES = '0;
  localparam lrof_pkg::lrof_res_t DROPPED_LAST =
    '{range_mm: lrof_pkg::RANGE_SAT, nan: 1'b0, removed: 1'b1, scan_end: 1'b1};
  localparam lrof_pkg::lrof_res_t PASSED_TOP_LAST =
    '{range_mm: lrof_pkg::RANGE_SAT, nan: 1'b0, removed: 1'b0, scan_end: 1'b1};

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [lrof_pkg::CfgIdxW-1:0] cfg_index;
  logic [lrof_pkg::RangeW-1:0]  cfg_wdata;

  lrof_in_if  in_ch ();
  lrof_out_if out_ch ();

  lidar_range_outlier_filter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // model state: registers, filtered left neighbour, sample awaiting its right one
  lrof_pkg::lrof_cfg_t         regs;
  logic [lrof_pkg::RangeW-1:0] left_mm;
  logic                        left_nan;
  logic [lrof_pkg::RangeW-1:0] held_mm;
  logic                        held_nan;
  logic                        held_valid;
  logic                        held_first;

  lrof_pkg::lrof_res_t due_filtered [$];
  lrof_pkg::lrof_res_t head;

  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_req     = 0;
  int quiet_cycles = 0;
  int fails        = 0;
  int samples_sent = 0;
  int scans_sent   = 0;
  int results_seen = 0;
  int removed_seen = 0;
  int reg_writes   = 0;

  // outlier decision for one sample given its two neighbours
  function automatic lrof_pkg::lrof_res_t decide_sample(
      input logic [lrof_pkg::RangeW-1:0] x, input logic x_nan,
      input logic l_here, input logic l_nan, input logic [lrof_pkg::RangeW-1:0] l_mm,
      input logic r_here, input logic r_nan, input logic [lrof_pkg::RangeW-1:0] r_mm);
    lrof_pkg::lrof_res_t         res;
    logic                        usable;
    logic                        l_far;
    logic                        r_far;
    logic                        drop;
    logic [lrof_pkg::RangeW-1:0] l_diff;
    logic [lrof_pkg::RangeW-1:0] r_diff;
    usable = (l_here && !l_nan && l_mm > regs.range_floor && l_mm < regs.range_ceiling) ||
             (r_here && !r_nan && r_mm > regs.range_floor && r_mm < regs.range_ceiling);
    l_diff = (l_mm > x) ? l_mm - x : x - l_mm;
    r_diff = (r_mm > x) ? r_mm - x : x - r_mm;
    // a nan neighbour never counts as too far
    l_far = !l_here || (!l_nan && l_diff > regs.neighbour_gap);
    r_far = !r_here || (!r_nan && r_diff > regs.neighbour_gap);
    if (x_nan) begin
      drop = !usable;
    end else if (x > regs.range_ceiling || x < regs.range_floor) begin
      drop = 1'b0;
    end else if (x < regs.near_cutoff) begin
      drop = 1'b1;
    end else begin
      drop = !usable || (l_far && r_far);
    end
    res.removed  = drop;
    res.scan_end = 1'b0;
    res.nan      = !drop && x_nan;
    if (drop) begin
      res.range_mm = (regs.range_ceiling == lrof_pkg::RANGE_SAT)
                     ? lrof_pkg::RANGE_SAT
                     : regs.range_ceiling + 1'b1;
    end else begin
      res.range_mm = x_nan ? '0 : x;
    end
    return res;
  endfunction

  // one accepted sample: release the held one, and on scan end this one too
  function automatic void advance_scan(input logic [lrof_pkg::RangeW-1:0] mm,
                                       input logic nn, input logic last);
    lrof_pkg::lrof_res_t res;
    logic                had_held;
    had_held = held_valid;
    if (held_valid) begin
      res = decide_sample(held_mm, held_nan, !held_first, left_nan, left_mm,
                          1'b1, nn, mm);
      due_filtered.push_back(res);
      left_mm    = res.range_mm;
      left_nan   = res.nan;
      held_first = 1'b0;
    end
    if (last) begin
      res = decide_sample(mm, nn, had_held, left_nan, left_mm, 1'b0, 1'b0, '0);
      res.scan_end = 1'b1;
      due_filtered.push_back(res);
      left_mm    = res.range_mm;
      left_nan   = res.nan;
      held_valid = 1'b0;
      held_first = 1'b1;
      scans_sent++;
    end else begin
      held_mm    = mm;
      held_nan   = nn;
      held_valid = 1'b1;
    end
  endfunction

  // offer one sample after a random gap and wait for the beat
  task automatic offer_beat(input logic [lrof_pkg::RangeW-1:0] mm, input logic nn,
                            input logic last);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.range_mm <= mm;
    in_ch.is_nan   <= nn;
    in_ch.scan_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    advance_scan(mm, nn, last);
    samples_sent++;
  endtask

  // stop offering until every due result is out, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lrof_pkg::CfgIdxW-1:0] idx,
                           input logic [lrof_pkg::RangeW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lrof_pkg::CFG_RANGE_FLOOR:   regs.range_floor   = val;
      lrof_pkg::CFG_RANGE_CEILING: regs.range_ceiling = val;
      lrof_pkg::CFG_NEAR_CUTOFF:   regs.near_cutoff   = val;
      default:                     regs.neighbour_gap = val;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result beats against the oldest due result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (due_filtered.size() == 0) begin
        $error("result beat with nothing due: out_range_mm %0d", out_ch.out_range_mm);
        fails++;
      end else begin
        head = due_filtered.pop_front();
        if (head.removed) removed_seen++;
        if (out_ch.out_range_mm !== head.range_mm) begin
          $error("out_range_mm: expected %0d, got %0d", head.range_mm, out_ch.out_range_mm);
          fails++;
        end
        if (out_ch.out_nan !== head.nan) begin
          $error("out_nan: expected %0b, got %0b", head.nan, out_ch.out_nan);
          fails++;
        end
        if (out_ch.was_removed !== head.removed) begin
          $error("was_removed: expected %0b, got %0b", head.removed, out_ch.was_removed);
          fails++;
        end
        if (out_ch.out_scan_end !== head.scan_end) begin
          $error("out_scan_end: expected %0b, got %0b", head.scan_end, out_ch.out_scan_end);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin : watchdog
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat for %0d cycles, %0d results still due",
                 quiet_cycles, due_filtered.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t                   rows [NROWS];
    stim_row_t                   row;
    int                          fl;
    int                          ce;
    int                          ne;
    int                          gp;
    int                          lo;
    int                          hi;
    int                          walk_mm;
    int                          step_max;
    int                          scan_len;
    int                          pick;
    int                          ph_beats;
    logic [lrof_pkg::RangeW-1:0] mm;
    logic                        nn;

    // directed scans: single-sample scans carry their result in the table
    rows = '{
      // reset registers: lone samples have no neighbours
      '{ROW_BEAT,  '0,                          16'd100,  1'b0, 1'b1, 1'b1, DROPPED_LAST},
      '{ROW_BEAT,  '0,                          16'hFFFF, 1'b0, 1'b1, 1'b1, PASSED_TOP_LAST},
      '{ROW_BEAT,  '0,                          16'hFFFF, 1'b1, 1'b1, 1'b1, DROPPED_LAST},
      '{ROW_BEAT,  '0,                          16'd0,    1'b0, 1'b1, 1'b1, DROPPED_LAST},
      // a typical window with every kind of sample in one scan
      '{ROW_WRITE, lrof_pkg::CFG_RANGE_FLOOR,   16'd100,  1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_WRITE, lrof_pkg::CFG_RANGE_CEILING, 16'd5000, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_WRITE, lrof_pkg::CFG_NEAR_CUTOFF,   16'd300,  1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_WRITE, lrof_pkg::CFG_NEIGHBOUR_GAP, 16'd50,   1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd1000, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd1020, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd2000, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd0,    1'b1, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd1010, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd200,  1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd50,   1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd6000, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd1000, 1'b0, 1'b1, 1'b0, NO_RES},
      // ceiling at its top value: replacement saturates
      '{ROW_WRITE, lrof_pkg::CFG_RANGE_CEILING, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_WRITE, lrof_pkg::CFG_RANGE_FLOOR,   16'd0,    1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_WRITE, lrof_pkg::CFG_NEAR_CUTOFF,   16'd0,    1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_WRITE, lrof_pkg::CFG_NEIGHBOUR_GAP, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd7,    1'b0, 1'b1, 1'b1, DROPPED_LAST},
      '{ROW_BEAT,  '0,                          16'd10,   1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd20,   1'b0, 1'b1, 1'b0, NO_RES},
      // zero gap: only equal neighbours keep a sample
      '{ROW_WRITE, lrof_pkg::CFG_NEIGHBOUR_GAP, 16'd0,    1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd500,  1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd500,  1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd501,  1'b0, 1'b1, 1'b0, NO_RES},
      // near cut-off at its top, nan closing a scan
      '{ROW_WRITE, lrof_pkg::CFG_NEAR_CUTOFF,   16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'hFFFF, 1'b0, 1'b1, 1'b1, DROPPED_LAST},
      '{ROW_BEAT,  '0,                          16'd1234, 1'b0, 1'b0, 1'b0, NO_RES},
      '{ROW_BEAT,  '0,                          16'd1234, 1'b1, 1'b1, 1'b0, NO_RES}
    };

    in_ch.valid    <= 1'b0;
    in_ch.range_mm <= '0;
    in_ch.is_nan   <= 1'b0;
    in_ch.scan_end <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    regs = '{range_floor: '0, range_ceiling: 16'd65534, near_cutoff: '0, neighbour_gap: '0};
    left_mm    = '0;
    left_nan   = 1'b0;
    held_mm    = '0;
    held_nan   = 1'b0;
    held_valid = 1'b0;
    held_first = 1'b1;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.reg_idx, row.value);
      end else begin
        offer_beat(row.value, row.nan, row.last);
        if (row.typed) begin
          void'(due_filtered.pop_back());
          due_filtered.push_back(row.want);
        end
      end
    end

    // random scans, one register setting and flow-control mix per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin fl = 0;     ce = 65534; ne = 0;     gp = 0;     end
        1: begin fl = 1000;  ce = 9000;  ne = 1500;  gp = 40;    end
        5: begin fl = 65534; ce = 65534; ne = 65535; gp = 65535; end
        6: begin fl = 40000; ce = 300;   ne = 0;     gp = 10;    end
        default: begin
          fl = $urandom_range(0, 3000);
          ce = $urandom_range(fl + 2000, 65534);
          ne = $urandom_range(fl, fl + 1000);
          gp = $urandom_range(0, 400);
        end
      endcase
      write_reg(lrof_pkg::CFG_RANGE_FLOOR,   lrof_pkg::RangeW'(fl));
      write_reg(lrof_pkg::CFG_RANGE_CEILING, lrof_pkg::RangeW'(ce));
      write_reg(lrof_pkg::CFG_NEAR_CUTOFF,   lrof_pkg::RangeW'(ne));
      write_reg(lrof_pkg::CFG_NEIGHBOUR_GAP, lrof_pkg::RangeW'(gp));

      case (ph % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 61; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase

      lo       = (fl < ce) ? fl : ce;
      hi       = (fl < ce) ? ce : fl;
      step_max = (gp > 13000) ? 20000 : gp + gp / 2 + 2;
      ph_beats = 0;
      while (ph_beats < PHASE_BEATS) begin
        scan_len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
        walk_mm  = $urandom_range(lo, hi);
        for (int k = 0; k < scan_len; k++) begin
          pick = $urandom_range(99);
          nn   = (pick < 7);
          if (pick < 20) begin
            mm = lrof_pkg::RangeW'($urandom);
          end else if (pick < 80) begin
            // surface walk: mostly within the gap, sometimes just beyond
            walk_mm += int'($urandom_range(0, 2 * step_max)) - step_max;
            if (walk_mm < 0) walk_mm = 0;
            if (walk_mm > 65535) walk_mm = 65535;
            mm = lrof_pkg::RangeW'(walk_mm);
          end else if (pick < 88) begin
            case ($urandom_range(3))
              0:       mm = lrof_pkg::RangeW'(fl);
              1:       mm = lrof_pkg::RangeW'(ce);
              2:       mm = lrof_pkg::RangeW'(ne);
              default: mm = lrof_pkg::RangeW'(ce + 1);
            endcase
          end else begin
            mm = lrof_pkg::RangeW'($urandom_range(lo, hi));
          end
          offer_beat(mm, nn, k == scan_len - 1);
          ph_beats++;
          // receiver holds off while samples keep coming
          if (ph == 0 && ph_beats == 60) hold_req = HOLD_CYCLES;
          // sender pauses mid-scan until the results have drained
          if (ph == 1 && ph_beats == 90) settle();
        end
      end
    end

    in_ch.valid <= 1'b0;
    for (int k = 0; k < QUIET_LIMIT && due_filtered.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_filtered.size() != 0) begin
      $error("%0d results never arrived", due_filtered.size());
      fails++;
    end

    $display("%0d samples in %0d scans, %0d result beats checked, %0d of them removed",
             samples_sent, scans_sent, results_seen, removed_seen);
    $display("%0d register writes over %0d settings, with stalls, gaps and a long hold-off",
             reg_writes, PHASES + 4);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
